// ===== rtl/core/csa_pkg.sv =====
// Shared types and constants for the circular slot allocator.
// Holds the occupancy word layout, the field widths and the command codes.
// No dependencies.
package csa_pkg;

	// one memory word holds the full flags of sixteen children
	localparam int FAN_LOG = 4;
	localparam int FAN     = 1 << FAN_LOG;

	// start position of a scan within a word; FAN means no position left
	localparam int START_W = FAN_LOG + 1;

	// fixed field widths of the ports
	localparam int SLOT_W = 10;
	localparam int CNT_W  = 11;

	localparam logic [CNT_W-1:0] CNT_RESET = 11'd1024;

	// request commands
	localparam logic CMD_ENTER = 1'b0;
	localparam logic CMD_LEAVE = 1'b1;

	typedef logic [FAN-1:0]     word_t;
	typedef logic [FAN_LOG-1:0] pos_t;
	typedef logic [START_W-1:0] start_t;

	// outcome of one word evaluation
	typedef struct packed {
		logic  hit;       // a free child exists at or after the start position
		pos_t  pos;       // lowest such child
		word_t new_word;  // word after the set or clear of one flag
		logic  prop;      // the change must travel to the parent level
	} step_res_t;

endpackage

// ===== rtl/core/csa_step.sv =====
// Word evaluation for the occupancy tree: first-free scan and flag update.
// Purely combinational; depends on csa_pkg.
module csa_step import csa_pkg::*; (
	input  word_t     word,
	input  start_t    start,
	input  pos_t      upd_pos,
	input  logic      set_op,
	output step_res_t res
);

	word_t cand;
	word_t one_hot;
	word_t upd_word;
	pos_t  first_pos;

	// mask the free children at or after the start position
	always_comb begin
		for (int b = 0; b < FAN; b++) begin
			cand[b] = !word[b] && (START_W'(b) >= start);
		end
	end

	// pick the lowest candidate
	always_comb begin
		first_pos = '0;
		for (int b = FAN - 1; b >= 0; b--) begin
			if (cand[b]) begin
				first_pos = pos_t'(b);
			end
		end
	end

	// set or clear one flag; report when the parent flag changes with it
	assign one_hot  = word_t'(1) << upd_pos;
	assign upd_word = set_op ? (word | one_hot) : (word & ~one_hot);

	assign res = '{
		hit:      |cand,
		pos:      first_pos,
		new_word: upd_word,
		prop:     set_op ? (&upd_word) : (&word)
	};

endmodule

// ===== rtl/core/circular_next_free_slot_allocator.sv =====
// Top level of the circular next-free slot allocator: control, tree memory, result register.
// Depends on csa_pkg and csa_step.
//
//   channel  | handshake            | payload
//   ---------+----------------------+----------------------------
//   request  | in_valid / in_stall  | cmd, slot_index
//   result   | out_valid / out_stall| granted_slot, all_full
//   config   | cfg_we               | cfg_wdata (slot count)
//
// Occupancy lives in one 16-way tree of full flags in a single memory with a registered read.
// An enter walks the tree levels (three for SLOTS=1024) in this order:
// a climb-and-descend scan, a scan from the root after wrap, then a flag update up the path.
// A leave clears flags up the path; an out-of-range leave finishes at acceptance.
// After reset a clearing pass writes every tree word, one per cycle (69 words at SLOTS=1024).
// A pending result holds under out_stall; the next request is taken while it waits.
module circular_next_free_slot_allocator import csa_pkg::*; #(
	parameter int SLOTS = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              cmd,
	input  logic [SLOT_W-1:0] slot_index,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [SLOT_W-1:0] granted_slot,
	output logic              all_full,
	input  logic              cfg_we,
	input  logic [CNT_W-1:0]  cfg_wdata
);

	localparam int LEVELS = ($clog2(SLOTS) + FAN_LOG - 1) / FAN_LOG;
	localparam int IW     = FAN_LOG * LEVELS;
	localparam int LW     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int NW0    = $clog2(SLOTS + 1);
	localparam int NW1    = (NW0 > CNT_W) ? NW0 : CNT_W;
	localparam int CW     = (NW1 > IW) ? NW1 : IW;

	function automatic int level_nodes(input int j);
		return ((SLOTS - 1) >> (FAN_LOG * (j + 1))) + 1;
	endfunction

	// words stored above level k; the root sits at address zero
	function automatic int level_base(input int k);
		int s;
		s = 0;
		for (int j = k + 1; j < LEVELS; j++) begin
			s = s + level_nodes(j);
		end
		return s;
	endfunction

	localparam int DEPTH = level_base(0) + level_nodes(0);
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SW    = (AW > IW) ? AW : IW;

	localparam logic [LW-1:0] TOP = LW'(LEVELS - 1);

	typedef enum logic [5:0] {
		ST_CLEAR  = 6'b000001,
		ST_IDLE   = 6'b000010,
		ST_READ   = 6'b000100,
		ST_SEARCH = 6'b001000,
		ST_UPDATE = 6'b010000,
		ST_RESULT = 6'b100000
	} state_t;

	state_t           state_q;
	logic [AW-1:0]    clr_q;
	logic [CNT_W-1:0] slot_count_q;
	logic [LW-1:0]    lvl_q;
	logic [IW-1:0]    node_q;
	start_t           start_q;
	pos_t             upd_pos_q;
	logic             set_q;
	logic             upd_q;
	logic             pass_q;
	logic             enter_q;
	logic [IW-1:0]    lo_q;
	logic [IW-1:0]    g_q;
	logic             full_q;
	logic [AW-1:0]    addr_q;
	word_t            rdata_q;
	logic             out_valid_q;
	logic [SLOT_W-1:0] granted_q;
	logic             all_full_q;

	word_t            mem [DEPTH];

	logic [CW-1:0]    n_eff;
	logic             in_range;
	logic [IW-1:0]    lo_in;
	logic [AW-1:0]    base_cur;
	logic [CW-1:0]    lim_cur;
	logic [AW-1:0]    rd_addr;
	logic [IW-1:0]    child;
	logic             hit_ok;
	logic             at_top;
	logic             load_out;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	word_t            mem_wdata;
	step_res_t        step_res;

	// clamp the slot count into one to SLOTS
	always_comb begin
		if (slot_count_q == '0) begin
			n_eff = CW'(1);
		end else if (CW'(slot_count_q) > CW'(SLOTS)) begin
			n_eff = CW'(SLOTS);
		end else begin
			n_eff = CW'(slot_count_q);
		end
	end

	assign in_range = CW'(slot_index) < n_eff;
	assign lo_in    = in_range ? IW'(slot_index) : '0;

	// per-level base address and child limit
	always_comb begin
		base_cur = '0;
		lim_cur  = n_eff;
		for (int g = 0; g < LEVELS; g++) begin
			if (lvl_q == LW'(g)) begin
				base_cur = AW'(level_base(g));
				if (g > 0) begin
					lim_cur = CW'(level_nodes(g - 1));
				end
			end
		end
	end

	assign rd_addr = AW'(SW'(base_cur) + SW'(node_q));
	assign at_top  = (lvl_q == TOP);

	csa_step u_step (
		.word    (rdata_q),
		.start   (start_q),
		.upd_pos (upd_pos_q),
		.set_op  (set_q),
		.res     (step_res)
	);

	// a hit beyond the live children means nothing free in range
	assign child  = IW'({node_q, step_res.pos});
	assign hit_ok = step_res.hit && (CW'(child) < lim_cur);

	assign in_stall = (state_q != ST_IDLE);

	// tree memory: one write and one registered read port
	assign mem_we    = (state_q == ST_CLEAR) || (state_q == ST_UPDATE);
	assign mem_waddr = (state_q == ST_CLEAR) ? clr_q : addr_q;
	assign mem_wdata = (state_q == ST_CLEAR) ? '0 : step_res.new_word;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (state_q == ST_READ) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// hold the slot count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= CNT_RESET;
		end else if (cfg_we) begin
			slot_count_q <= cfg_wdata;
		end
	end

	// sequencer state and clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= AW'(clr_q + AW'(1));
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid && (cmd == CMD_ENTER || in_range)) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= upd_q ? ST_UPDATE : ST_SEARCH;
				end
				ST_SEARCH: begin
					if (hit_ok && lvl_q == '0) begin
						state_q <= (!pass_q || child < lo_q) ? ST_READ : ST_RESULT;
					end else if (hit_ok || (!step_res.hit && !at_top) || !pass_q) begin
						state_q <= ST_READ;
					end else begin
						state_q <= ST_RESULT;
					end
				end
				ST_UPDATE: begin
					if (step_res.prop && !at_top) begin
						state_q <= ST_READ;
					end else begin
						state_q <= enter_q ? ST_RESULT : ST_IDLE;
					end
				end
				ST_RESULT: begin
					if (!out_valid_q || !out_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	// walk registers: level, node, scan start, update position
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				lvl_q     <= '0;
				lo_q      <= lo_in;
				node_q    <= lo_in >> FAN_LOG;
				start_q   <= START_W'(lo_in[FAN_LOG-1:0]);
				upd_pos_q <= lo_in[FAN_LOG-1:0];
				pass_q    <= 1'b0;
				set_q     <= 1'b0;
				enter_q   <= (cmd == CMD_ENTER);
				upd_q     <= (cmd == CMD_LEAVE);
			end
			ST_READ: begin
				addr_q <= rd_addr;
			end
			ST_SEARCH: begin
				if (hit_ok && lvl_q == '0) begin
					// grant on the first pass, or when the wrapped scan lands below the wanted slot
					if (!pass_q || child < lo_q) begin
						g_q       <= child;
						full_q    <= 1'b0;
						node_q    <= child >> FAN_LOG;
						upd_pos_q <= child[FAN_LOG-1:0];
						set_q     <= 1'b1;
						upd_q     <= 1'b1;
					end else begin
						g_q    <= '0;
						full_q <= 1'b1;
					end
				end else if (hit_ok) begin
					// descend into the free child
					lvl_q   <= LW'(lvl_q - LW'(1));
					node_q  <= child;
					start_q <= '0;
				end else if (!step_res.hit && !at_top) begin
					// climb and resume right of the current node
					lvl_q   <= LW'(lvl_q + LW'(1));
					node_q  <= node_q >> FAN_LOG;
					start_q <= START_W'(node_q[FAN_LOG-1:0]) + START_W'(1);
				end else if (!pass_q) begin
					// wrap: scan again from the root
					pass_q  <= 1'b1;
					lvl_q   <= TOP;
					node_q  <= '0;
					start_q <= '0;
				end else begin
					g_q    <= '0;
					full_q <= 1'b1;
				end
			end
			ST_UPDATE: begin
				lvl_q     <= LW'(lvl_q + LW'(1));
				node_q    <= node_q >> FAN_LOG;
				upd_pos_q <= node_q[FAN_LOG-1:0];
			end
			default: begin
			end
		endcase
	end

	// result register: load when empty or being drained
	assign load_out = (state_q == ST_RESULT) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			granted_q  <= SLOT_W'(g_q);
			all_full_q <= full_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign granted_slot = granted_q;
	assign all_full     = all_full_q;

endmodule

// ===== rtl/core/csa_checker.sv =====
// Port-level checks for the circular slot allocator, bound to its top level.
// Depends on csa_pkg and circular_next_free_slot_allocator.
module csa_checker import csa_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              cmd,
	input logic              out_valid,
	input logic              out_stall,
	input logic [SLOT_W-1:0] granted_slot,
	input logic              all_full
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(granted_slot) && $stable(all_full))
		else $error("stalled result changed");

	// a full ring reports slot zero
	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && all_full |-> granted_slot == '0)
		else $error("full result carries a nonzero slot");

	// an enter request keeps the block busy on the next cycle
	a_enter_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && cmd == CMD_ENTER |=> in_stall)
		else $error("enter request did not occupy the block");

	// a new result only appears out of a busy cycle
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared while idle");

endmodule

bind circular_next_free_slot_allocator csa_checker u_csa_checker (.*);

// ===== bench/tb.sv =====
// Self-checking bench for circular_next_free_slot_allocator: a directed table, then random phases.
// Grants are predicted from a local occupancy map and slot count; needs csa_pkg and the RTL only.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import csa_pkg::*;

	localparam int RING_MAX        = 1024;
	localparam int SETTLE_CYCLES   = 64;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int RANDOM_PHASES   = 24;
	localparam int RANDOM_ITEMS    = 1625;

	typedef struct packed {
		logic              full;
		logic [SLOT_W-1:0] slot;
	} grant_t;

	typedef enum logic {ROW_REQUEST, ROW_SET_COUNT} plan_kind_t;

	typedef struct packed {
		plan_kind_t        kind;
		logic              op;
		logic [SLOT_W-1:0] slot;
		logic [CNT_W-1:0]  count;
		logic              typed;
		grant_t            want;
	} plan_row_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic              cmd;
	logic [SLOT_W-1:0] slot_index;
	logic              out_valid;
	logic              out_stall;
	logic [SLOT_W-1:0] granted_slot;
	logic              all_full;
	logic              cfg_we;
	logic [CNT_W-1:0]  cfg_wdata;

	// local copy of the ring state and the pending grants
	logic [RING_MAX-1:0] occupied_map;
	logic [CNT_W-1:0]    ring_size;
	grant_t              grant_queue[$];
	grant_t              head;
	int                  err_count = 0;
	bit                  hold_off_req = 1'b0;
	bit                  quiet_phase = 1'b0;

	circular_next_free_slot_allocator #(
		.SLOTS(RING_MAX)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.slot_index  (slot_index),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.granted_slot(granted_slot),
		.all_full    (all_full),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Clamp the programmed count to the range the ring really uses.
	function automatic int live_slots();
		int n;
		n = int'(ring_size);
		if (n == 0) n = 1;
		if (n > RING_MAX) n = RING_MAX;
		return n;
	endfunction

	// Apply one accepted request to the map; return the grant an enter produces.
	function automatic grant_t allocate_or_free(input logic op, input logic [SLOT_W-1:0] sel);
		int n, start, pick, s;
		grant_t g;
		n = live_slots();
		g.full = 1'b1;
		g.slot = '0;
		if (op == CMD_LEAVE) begin
			if (int'(sel) < n) occupied_map[sel] = 1'b0;
			return g;
		end
		// search from the wanted slot, wrapping past the top
		start = (int'(sel) < n) ? int'(sel) : 0;
		pick = -1;
		for (int k = 0; k < n; k++) begin
			s = (start + k) % n;
			if (pick < 0 && !occupied_map[s]) pick = s;
		end
		if (pick >= 0) begin
			occupied_map[pick] = 1'b1;
			g.full = 1'b0;
			g.slot = SLOT_W'(pick);
		end
		return g;
	endfunction

	// Pick a slot for a random request; leaves mostly target an occupied slot.
	function automatic logic [SLOT_W-1:0] random_slot(input logic op);
		int n, r, s, base;
		n = live_slots();
		r = $urandom_range(0, 99);
		if (op == CMD_LEAVE && r < 60) begin
			base = $urandom_range(0, n - 1);
			for (int k = 0; k < n; k++) begin
				s = (base + k) % n;
				if (occupied_map[s]) return SLOT_W'(s);
			end
			return SLOT_W'(base);
		end
		if (r < 85) return SLOT_W'($urandom_range(0, n - 1));
		if (r < 93) return SLOT_W'($urandom_range(0, RING_MAX - 1));
		unique case ($urandom_range(0, 2))
			0: return '0;
			1: return SLOT_W'(n - 1);
			default: return '1;
		endcase
	endfunction

	function automatic plan_row_t row_req(input logic op, input logic [SLOT_W-1:0] sel);
		plan_row_t r;
		r = '0;
		r.kind = ROW_REQUEST;
		r.op = op;
		r.slot = sel;
		return r;
	endfunction

	function automatic plan_row_t row_grant(input logic [SLOT_W-1:0] sel, input logic full,
			input logic [SLOT_W-1:0] got);
		plan_row_t r;
		r = row_req(CMD_ENTER, sel);
		r.typed = 1'b1;
		r.want.full = full;
		r.want.slot = got;
		return r;
	endfunction

	function automatic plan_row_t row_count(input logic [CNT_W-1:0] value);
		plan_row_t r;
		r = '0;
		r.kind = ROW_SET_COUNT;
		r.count = value;
		return r;
	endfunction

	// Offer one request after a random gap; hold it until accepted.
	task automatic issue_request(input logic op, input logic [SLOT_W-1:0] sel,
			input logic typed, input grant_t typed_grant);
		int r, gap;
		grant_t g;
		r = $urandom_range(0, 99);
		if (quiet_phase || r < 50) gap = 0;
		else if (r < 85) gap = $urandom_range(1, 3);
		else if (r < 97) gap = $urandom_range(4, 12);
		else gap = $urandom_range(20, 60);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		slot_index <= sel;
		do @(posedge clk); while (in_stall !== 1'b0);
		g = allocate_or_free(op, sel);
		if (op == CMD_ENTER) grant_queue.push_back(typed ? typed_grant : g);
		@(negedge clk);
	endtask

	// Drain all grants, let a trailing leave finish, then program the slot count.
	task automatic set_slot_count(input logic [CNT_W-1:0] value);
		in_valid <= 1'b0;
		while (grant_queue.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		ring_size = value;
	endtask

	// Result side: random stall runs, quiet stretches, and one long hold-off on request.
	initial begin : result_receiver
		logic stall_lvl;
		int run, r;
		stall_lvl = 1'b0;
		run = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				stall_lvl = 1'b1;
				run = HOLD_OFF_CYCLES;
			end else if (run == 0) begin
				r = $urandom_range(0, 99);
				if (quiet_phase || r < 55) begin
					stall_lvl = 1'b0;
					run = $urandom_range(1, 8);
				end else if (r < 88) begin
					stall_lvl = 1'b1;
					run = $urandom_range(1, 3);
				end else if (r < 97) begin
					stall_lvl = 1'b1;
					run = $urandom_range(4, 12);
				end else begin
					stall_lvl = 1'b1;
					run = $urandom_range(20, 60);
				end
			end
			out_stall <= stall_lvl;
			run--;
		end
	end

	// Compare every accepted grant with the oldest prediction.
	always @(posedge clk) begin
		if (out_valid === 1'b1 && out_stall === 1'b0) begin
			if (grant_queue.size() == 0) begin
				$display("%0t: unexpected grant: slot %0d full %0b", $time, granted_slot, all_full);
				err_count++;
			end else begin
				head = grant_queue.pop_front();
				if (granted_slot !== head.slot) begin
					$display("%0t: granted_slot expected %0d actual %0d",
						$time, head.slot, granted_slot);
					err_count++;
				end
				if (all_full !== head.full) begin
					$display("%0t: all_full expected %0b actual %0b", $time, head.full, all_full);
					err_count++;
				end
			end
		end
	end

	initial begin : stimulus
		plan_row_t directed_plan[$];
		logic [CNT_W-1:0] fixed_counts[$];
		logic [CNT_W-1:0] count;
		logic [SLOT_W-1:0] sel;
		logic op;
		int n, phase_items, per_phase, r;

		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_ENTER;
		slot_index = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		occupied_map = '0;
		ring_size = CNT_RESET;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// at reset size: first fits, wrap at the top, refill of freed slots
		directed_plan.push_back(row_grant(10'd0, 1'b0, 10'd0));
		directed_plan.push_back(row_grant(10'd0, 1'b0, 10'd1));
		directed_plan.push_back(row_grant(10'd1023, 1'b0, 10'd1023));
		directed_plan.push_back(row_grant(10'd1023, 1'b0, 10'd2));
		directed_plan.push_back(row_req(CMD_LEAVE, 10'd1));
		directed_plan.push_back(row_grant(10'd0, 1'b0, 10'd1));
		directed_plan.push_back(row_req(CMD_LEAVE, 10'd1023));
		// leave of a slot that is already free
		directed_plan.push_back(row_req(CMD_LEAVE, 10'd1023));
		directed_plan.push_back(row_grant(10'd1022, 1'b0, 10'd1022));
		directed_plan.push_back(row_grant(10'd1022, 1'b0, 10'd1023));
		directed_plan.push_back(row_grant(10'h2AA, 1'b0, 10'h2AA));
		directed_plan.push_back(row_grant(10'h155, 1'b0, 10'h155));
		directed_plan.push_back(row_req(CMD_LEAVE, 10'd0));
		directed_plan.push_back(row_grant(10'd1023, 1'b0, 10'd0));
		// zero count acts as one slot: full ring, out-of-range leave and enter
		directed_plan.push_back(row_count(11'd0));
		directed_plan.push_back(row_grant(10'd0, 1'b1, 10'd0));
		directed_plan.push_back(row_req(CMD_LEAVE, 10'd5));
		directed_plan.push_back(row_grant(10'd5, 1'b1, 10'd0));
		directed_plan.push_back(row_req(CMD_LEAVE, 10'd0));
		directed_plan.push_back(row_grant(10'd1023, 1'b0, 10'd0));
		// oversized count acts as the full ring
		directed_plan.push_back(row_count(11'd2047));
		directed_plan.push_back(row_req(CMD_ENTER, 10'd1));
		directed_plan.push_back(row_req(CMD_ENTER, 10'd1023));
		// shrink: slots above the count keep their occupancy
		directed_plan.push_back(row_count(11'd3));
		directed_plan.push_back(row_grant(10'd2, 1'b1, 10'd0));
		directed_plan.push_back(row_req(CMD_LEAVE, 10'd3));
		directed_plan.push_back(row_count(11'd5));
		directed_plan.push_back(row_grant(10'd0, 1'b1, 10'd0));

		foreach (directed_plan[i]) begin
			if (directed_plan[i].kind == ROW_SET_COUNT) begin
				set_slot_count(directed_plan[i].count);
			end else begin
				issue_request(directed_plan[i].op, directed_plan[i].slot,
					directed_plan[i].typed, directed_plan[i].want);
			end
		end

		// random phases: extremes of the count first, then mostly small rings
		fixed_counts = '{11'd1024, 11'd1, 11'd2, 11'd2047, 11'd0, 11'd1023, 11'd16};
		per_phase = RANDOM_ITEMS / RANDOM_PHASES;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p < fixed_counts.size()) begin
				count = fixed_counts[p];
			end else begin
				r = $urandom_range(0, 99);
				if (r < 50) count = CNT_W'($urandom_range(1, 16));
				else if (r < 80) count = CNT_W'($urandom_range(17, RING_MAX));
				else count = CNT_W'($urandom_range(0, 2047));
			end
			set_slot_count(count);
			quiet_phase = (p != 0) && ($urandom_range(0, 4) == 0);
			// hold off the result side long enough to back up the request side
			if (p == 0) hold_off_req = 1'b1;
			phase_items = 0;
			while (phase_items < per_phase) begin
				n = live_slots();
				op = ($urandom_range(0, 99) < 62) ? CMD_ENTER : CMD_LEAVE;
				sel = random_slot(op);
				if (op == CMD_ENTER || int'(sel) < n) phase_items++;
				issue_request(op, sel, 1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		while (grant_queue.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (err_count == 0) begin
			$display("PASS circular_next_free_slot_allocator");
		end else begin
			$display("FAIL circular_next_free_slot_allocator");
		end
		$finish;
	end

	// Stop a hung run.
	initial begin : run_limit
		#10ms;
		$display("FAIL circular_next_free_slot_allocator");
		$finish;
	end

endmodule
